// ===== design/assert_macros.svh =====
// assertion macros shared by the button debounce block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold whenever the antecedent holds
`define BDPC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen
`define BDPC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ===== design/bdpc_pkg.sv =====
// types, constants and register codes for the button debounce press classifier
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 8;

    // register indexes
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_LONG_HOLD = 2'd1;
    localparam logic [1:0] REG_KIND_HOLD = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd0;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd1000;
    localparam logic [CFG_W-1:0] KIND_HOLD_RST = 16'd1000;

    // press kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_hold_ms;
        logic [CFG_W-1:0] kind_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] press_kind;
        logic       long_edge;
        logic       long_held;
        logic       press_edge;
        logic       held_level;
    } result_t;

endpackage

// ===== design/button_debounce_press_classifier_core.sv =====
// button debounce and press classifier: one result per raw sample.
// the result of a sample is registered and presented in the cycle after its transfer.
// one sample per cycle while the result channel is not stalled, set by the single-pass state update in bdpc_step.
// the output register lets a new sample in while the last result is being taken.
// reset (aresetn low, synchronous) clears all press state and the output valid,
// and restores the timing registers to their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_debounce_press_classifier_core #(
    parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdpc_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] pin_level
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] held_level, [1] press_edge, [2] long_held, [3] long_edge, [5:4] press_kind
    output logic [bdpc_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdpc_pkg::APB_AW-1:0]       paddr,
    input  logic [bdpc_pkg::APB_DW-1:0]       pwdata,
    output logic [bdpc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    bdpc_pkg::cfg_t    cfg;
    bdpc_pkg::result_t result;
    bdpc_pkg::result_t result_reg;
    logic              m_tvalid_reg;
    logic              s_xfer;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(bdpc_pkg::M_TDATA_W - $bits(bdpc_pkg::result_t)){1'b0}}, result_reg};

    bdpc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdpc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_xfer),
        .pin_level (s_tdata[0]),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            result_reg <= result;
        end
    end

    `BDPC_ASSERT_IMPLY(a_edge_level, m_tvalid && result_reg.press_edge, result_reg.held_level, "press edge without held level")
    `BDPC_ASSERT_IMPLY(a_long_edge, m_tvalid && result_reg.long_edge, result_reg.long_held, "long edge without long held")
    `BDPC_ASSERT_IMPLY(a_kind_long, m_tvalid && result_reg.press_kind == bdpc_pkg::KIND_LONG, result_reg.held_level, "long kind while released")
    `BDPC_ASSERT_IMPLY(a_kind_short, m_tvalid && result_reg.press_kind == bdpc_pkg::KIND_SHORT, !result_reg.held_level, "short kind while held")
    `BDPC_ASSERT_NEVER(a_kind_code, m_tvalid && result_reg.press_kind == 2'b11, "undefined press kind code")

endmodule

// ===== design/bdpc_apb_regs.sv =====
// apb register file holding the three timing registers
`timescale 1ns / 1ps

module bdpc_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bdpc_pkg::APB_AW-1:0]    paddr,
    input  logic [bdpc_pkg::APB_DW-1:0]    pwdata,
    output logic [bdpc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output bdpc_pkg::cfg_t                 cfg
);

    bdpc_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms  <= bdpc_pkg::DEBOUNCE_RST;
            cfg_reg.long_hold_ms <= bdpc_pkg::LONG_HOLD_RST;
            cfg_reg.kind_hold_ms <= bdpc_pkg::KIND_HOLD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bdpc_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ms  <= pwdata[bdpc_pkg::CFG_W-1:0];
                bdpc_pkg::REG_LONG_HOLD: cfg_reg.long_hold_ms <= pwdata[bdpc_pkg::CFG_W-1:0];
                bdpc_pkg::REG_KIND_HOLD: cfg_reg.kind_hold_ms <= pwdata[bdpc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bdpc_pkg::REG_DEBOUNCE:
                prdata = {{(bdpc_pkg::APB_DW-bdpc_pkg::CFG_W){1'b0}}, cfg_reg.debounce_ms};
            bdpc_pkg::REG_LONG_HOLD:
                prdata = {{(bdpc_pkg::APB_DW-bdpc_pkg::CFG_W){1'b0}}, cfg_reg.long_hold_ms};
            bdpc_pkg::REG_KIND_HOLD:
                prdata = {{(bdpc_pkg::APB_DW-bdpc_pkg::CFG_W){1'b0}}, cfg_reg.kind_hold_ms};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== design/bdpc_step.sv =====
// debounce, one-shot and press-kind state with its single-pass update logic
`timescale 1ns / 1ps

module bdpc_step #(
    parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                pin_level,
    input  bdpc_pkg::cfg_t      cfg,
    output bdpc_pkg::result_t   result
);

    localparam int CMP_W = (TIME_BITS > bdpc_pkg::CFG_W) ? TIME_BITS : bdpc_pkg::CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic                 holding_reg,      holding_next;
    logic [TIME_BITS-1:0] since_high_reg,   since_high_next;
    logic                 press_active_reg, press_active_next;
    logic [TIME_BITS-1:0] press_elapsed_reg, press_elapsed_next;
    logic                 edge_seen_reg,    edge_seen_next;
    logic                 long_seen_reg,    long_seen_next;
    logic                 kind_active_reg,  kind_active_next;
    logic [TIME_BITS-1:0] kind_elapsed_reg, kind_elapsed_next;
    logic                 kind_done_reg,    kind_done_next;

    logic [TIME_BITS-1:0] press_inc;
    logic [TIME_BITS-1:0] since_inc;
    logic [TIME_BITS-1:0] kind_inc;
    logic                 level;
    logic                 lheld;
    logic [1:0]           kind;

    // saturating increments
    assign press_inc = (press_elapsed_reg == TIME_MAX) ? TIME_MAX : press_elapsed_reg + 1'b1;
    assign since_inc = (since_high_reg == TIME_MAX) ? TIME_MAX : since_high_reg + 1'b1;
    assign kind_inc  = (kind_elapsed_reg == TIME_MAX) ? TIME_MAX : kind_elapsed_reg + 1'b1;

    always_comb begin
        holding_next       = holding_reg;
        since_high_next    = since_high_reg;
        press_active_next  = press_active_reg;
        press_elapsed_next = press_active_reg ? press_inc : press_elapsed_reg;
        kind_active_next   = kind_active_reg;
        kind_elapsed_next  = kind_elapsed_reg;
        kind_done_next     = kind_done_reg;
        kind               = bdpc_pkg::KIND_NONE;

        // debounced level, release only after the hold-off
        priority if (pin_level) begin
            holding_next    = 1'b1;
            since_high_next = '0;
            if (!press_active_reg) begin
                press_active_next  = 1'b1;
                press_elapsed_next = '0;
            end
            level = 1'b1;
        end else if (holding_reg) begin
            if (CMP_W'(since_inc) >= CMP_W'(cfg.debounce_ms)) begin
                holding_next       = 1'b0;
                since_high_next    = '0;
                press_active_next  = 1'b0;
                press_elapsed_next = '0;
                level              = 1'b0;
            end else begin
                since_high_next = since_inc;
                level           = 1'b1;
            end
        end else begin
            level = 1'b0;
        end

        edge_seen_next = level;
        lheld          = level && (CMP_W'(press_elapsed_next) >= CMP_W'(cfg.long_hold_ms));
        long_seen_next = lheld;

        // press kind: first held tick only starts the timer
        if (level) begin
            if (!kind_done_reg) begin
                if (!kind_active_reg) begin
                    kind_active_next  = 1'b1;
                    kind_elapsed_next = '0;
                end else begin
                    kind_elapsed_next = kind_inc;
                    if (CMP_W'(kind_inc) >= CMP_W'(cfg.kind_hold_ms)) begin
                        kind_done_next = 1'b1;
                        kind           = bdpc_pkg::KIND_LONG;
                    end
                end
            end
        end else begin
            if (!kind_done_reg && kind_active_reg) kind = bdpc_pkg::KIND_SHORT;
            kind_active_next  = 1'b0;
            kind_elapsed_next = '0;
            kind_done_next    = 1'b0;
        end

        result.held_level = level;
        result.press_edge = level && !edge_seen_reg;
        result.long_held  = lheld;
        result.long_edge  = lheld && !long_seen_reg;
        result.press_kind = kind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holding_reg       <= 1'b0;
            since_high_reg    <= '0;
            press_active_reg  <= 1'b0;
            press_elapsed_reg <= '0;
            edge_seen_reg     <= 1'b0;
            long_seen_reg     <= 1'b0;
            kind_active_reg   <= 1'b0;
            kind_elapsed_reg  <= '0;
            kind_done_reg     <= 1'b0;
        end else if (advance) begin
            holding_reg       <= holding_next;
            since_high_reg    <= since_high_next;
            press_active_reg  <= press_active_next;
            press_elapsed_reg <= press_elapsed_next;
            edge_seen_reg     <= edge_seen_next;
            long_seen_reg     <= long_seen_next;
            kind_active_reg   <= kind_active_next;
            kind_elapsed_reg  <= kind_elapsed_next;
            kind_done_reg     <= kind_done_next;
        end
    end

endmodule
